// ----- rtl/shared_channel_carrier_model_assert.svh -----
// Assertion macros shared by the channel model RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SHARED_CHANNEL_CARRIER_MODEL_ASSERT_SVH
`define SHARED_CHANNEL_CARRIER_MODEL_ASSERT_SVH

// Same-cycle implication
`define SCCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SCCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sccm_pkg.sv -----
// Package for the shared channel carrier model: action codes, register
// indexes, sequencer states and default sizes. No dependencies.
`default_nettype none

package sccm_pkg;

  localparam int NODES_DEF = 64;

  typedef enum logic [2:0] {
    ACT_ADD_LINK  = 3'd0,
    ACT_TRANSMIT  = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_HEARS     = 3'd3,
    ACT_CONNECTED = 3'd4
  } action_t;

  localparam logic CFG_SINGLE_CELL = 1'b0;
  localparam logic CFG_NODE_COUNT  = 1'b1;

  localparam logic [6:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NODE,
    ST_EVAL,
    ST_RD_PEER,
    ST_WR_PEER,
    ST_WALK,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/shared_channel_carrier_model.sv -----
// Shared radio channel carrier model: link rows, carrier counts, one bump unit.
// Each transaction reads its node row and count (ST_RD_NODE) and is evaluated (ST_EVAL).
// Hears/connected strobe out_valid from a register; add_link then reads and writes the
// peer row; a transmit of a 1 and a stop of a set flag walk the count memory through its
// single read port and the shared saturating bump unit, one node a cycle, then drain.
// Results cannot be stalled. Reset (synchronous, rst_n low) clears per-row and
// per-entry valid bits at once, so all stores read as zero with no clearing pass.
`default_nettype none

module shared_channel_carrier_model #(
  parameter int NODES = sccm_pkg::NODES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_action,
  input  wire logic [5:0] in_node,
  input  wire logic [5:0] in_peer,
  input  wire logic       in_tx_bit,
  output logic            out_valid,
  output logic            out_answer,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int IW = (AW > 6) ? AW : 6;
  localparam int HW = (AW > 7) ? AW : 7;

  // Configuration
  logic       cfg_single_r;
  logic [6:0] cfg_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_single_r <= 1'b0;
      cfg_count_r  <= sccm_pkg::NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sccm_pkg::CFG_SINGLE_CELL: cfg_single_r <= cfg_data[0];
        sccm_pkg::CFG_NODE_COUNT:  cfg_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Transaction capture
  sccm_pkg::action_t act_r;
  logic [5:0]        node_r;
  logic [5:0]        peer_r;
  logic              tx_bit_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r    <= sccm_pkg::action_t'(in_action);
      node_r   <= in_node;
      peer_r   <= in_peer;
      tx_bit_r <= in_tx_bit;
    end
  end

  logic [IW-1:0] node_ext, peer_ext;
  logic [AW-1:0] node_addr, peer_addr;
  logic          node_ok, peer_ok;

  assign node_ext  = IW'(node_r);
  assign peer_ext  = IW'(peer_r);
  assign node_addr = node_ext[AW-1:0];
  assign peer_addr = peer_ext[AW-1:0];
  assign node_ok   = {1'b0, node_ext} < (IW + 1)'(NODES);
  assign peer_ok   = {1'b0, peer_ext} < (IW + 1)'(NODES);

  // Link rows: bits NODES-1..0 are links, bit NODES is the sending flag
  logic [NODES:0]   row_mem [NODES];
  logic [NODES-1:0] row_vld_r;
  logic [NODES:0]   row_q_r;
  logic             row_vq_r;
  logic             row_rd_en, row_we;
  logic [AW-1:0]    row_rd_addr, row_waddr;
  logic [NODES:0]   row_wdata, row_eff;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_rd_en) begin
      row_q_r  <= row_mem[row_rd_addr];
      row_vq_r <= row_vld_r[row_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (row_we) begin
      row_vld_r[row_waddr] <= 1'b1;
    end
  end

  assign row_eff = row_vq_r ? row_q_r : '0;

  // Carrier counts
  logic [CW-1:0]    cnt_mem [NODES];
  logic [NODES-1:0] cnt_vld_r;
  logic [CW-1:0]    cnt_q_r;
  logic             cnt_vq_r;
  logic             cnt_rd_en, cnt_we;
  logic [AW-1:0]    cnt_rd_addr;
  logic [CW-1:0]    cnt_wdata, cnt_eff;
  logic [AW-1:0]    pipe_addr_r, pipe_addr_nxt;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[pipe_addr_r] <= cnt_wdata;
    end
    if (cnt_rd_en) begin
      cnt_q_r  <= cnt_mem[cnt_rd_addr];
      cnt_vq_r <= cnt_vld_r[cnt_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[pipe_addr_r] <= 1'b1;
    end
  end

  assign cnt_eff = cnt_vq_r ? cnt_q_r : '0;

  // Sequencer and walk registers
  sccm_pkg::state_t state_r, state_nxt;
  logic [NODES-1:0] links_r, links_nxt;
  logic             up_r, up_nxt;
  logic [AW-1:0]    wcnt_r, wcnt_nxt;
  logic             wlast;
  logic             pipe_vld_r, pipe_vld_nxt;
  logic             pipe_hit_r, pipe_hit_nxt;
  logic             out_valid_nxt, out_answer_nxt;

  assign wlast = (wcnt_r == AW'(NODES - 1));
  assign busy  = (state_r != sccm_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sccm_pkg::ST_IDLE:    if (start) state_nxt = sccm_pkg::ST_RD_NODE;
      sccm_pkg::ST_RD_NODE: state_nxt = sccm_pkg::ST_EVAL;
      sccm_pkg::ST_EVAL: begin
        case (act_r)
          sccm_pkg::ACT_ADD_LINK:
            state_nxt = (node_ok && peer_ok) ? sccm_pkg::ST_RD_PEER : sccm_pkg::ST_IDLE;
          sccm_pkg::ACT_TRANSMIT:
            state_nxt = (node_ok && tx_bit_r) ? sccm_pkg::ST_WALK : sccm_pkg::ST_IDLE;
          sccm_pkg::ACT_STOP:
            state_nxt = (node_ok && row_eff[NODES]) ? sccm_pkg::ST_WALK : sccm_pkg::ST_IDLE;
          default: state_nxt = sccm_pkg::ST_IDLE;
        endcase
      end
      sccm_pkg::ST_RD_PEER: state_nxt = sccm_pkg::ST_WR_PEER;
      sccm_pkg::ST_WR_PEER: state_nxt = sccm_pkg::ST_IDLE;
      sccm_pkg::ST_WALK:    if (wlast) state_nxt = sccm_pkg::ST_DRAIN;
      sccm_pkg::ST_DRAIN:   state_nxt = sccm_pkg::ST_IDLE;
      default:              state_nxt = sccm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    row_rd_en      = 1'b0;
    row_rd_addr    = node_addr;
    row_we         = 1'b0;
    row_waddr      = node_addr;
    row_wdata      = row_eff;
    cnt_rd_en      = 1'b0;
    cnt_rd_addr    = node_addr;
    out_valid_nxt  = 1'b0;
    out_answer_nxt = 1'b0;
    links_nxt      = links_r;
    up_nxt         = up_r;
    wcnt_nxt       = wcnt_r;
    pipe_vld_nxt   = 1'b0;
    pipe_addr_nxt  = wcnt_r;
    pipe_hit_nxt   = 1'b0;
    case (state_r)
      sccm_pkg::ST_RD_NODE: begin
        row_rd_en = 1'b1;
        cnt_rd_en = 1'b1;
      end
      sccm_pkg::ST_EVAL: begin
        links_nxt = row_eff[NODES-1:0];
        wcnt_nxt  = '0;
        case (act_r)
          sccm_pkg::ACT_ADD_LINK: begin
            row_we               = node_ok && peer_ok;
            row_wdata[peer_addr] = 1'b1;
          end
          sccm_pkg::ACT_TRANSMIT: begin
            row_we           = node_ok;
            row_wdata[NODES] = tx_bit_r;
            up_nxt           = 1'b1;
          end
          sccm_pkg::ACT_STOP: begin
            row_we           = node_ok && row_eff[NODES];
            row_wdata[NODES] = 1'b0;
            up_nxt           = 1'b0;
          end
          sccm_pkg::ACT_HEARS: begin
            out_valid_nxt  = 1'b1;
            out_answer_nxt = node_ok && cnt_vq_r && (cnt_q_r != '0);
          end
          sccm_pkg::ACT_CONNECTED: begin
            out_valid_nxt  = 1'b1;
            out_answer_nxt = node_ok && peer_ok && row_eff[peer_addr];
          end
          default: ;
        endcase
      end
      sccm_pkg::ST_RD_PEER: begin
        row_rd_en   = 1'b1;
        row_rd_addr = peer_addr;
      end
      sccm_pkg::ST_WR_PEER: begin
        row_we               = 1'b1;
        row_waddr            = peer_addr;
        row_wdata[node_addr] = 1'b1;
      end
      sccm_pkg::ST_WALK: begin
        // read node wcnt now, update it next cycle
        cnt_rd_en    = 1'b1;
        cnt_rd_addr  = wcnt_r;
        pipe_vld_nxt = 1'b1;
        pipe_hit_nxt = cfg_single_r ? (HW'(wcnt_r) < HW'(cfg_count_r)) : links_r[wcnt_r];
        wcnt_nxt     = wcnt_r + AW'(1);
      end
      default: ;
    endcase
  end

  // Shared saturating bump unit
  always_comb begin
    cnt_we    = pipe_vld_r && pipe_hit_r;
    cnt_wdata = cnt_eff;
    if (up_r) begin
      if (cnt_eff < CW'(NODES)) cnt_wdata = cnt_eff + CW'(1);
    end else begin
      if (cnt_eff != '0) cnt_wdata = cnt_eff - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sccm_pkg::ST_IDLE;
      pipe_vld_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      out_valid  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    links_r     <= links_nxt;
    up_r        <= up_nxt;
    wcnt_r      <= wcnt_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    pipe_hit_r  <= pipe_hit_nxt;
    out_answer  <= out_answer_nxt;
  end

  logic eval_query, walk_last, drain_vld;

  assign eval_query = (state_r == sccm_pkg::ST_EVAL) &&
                      (act_r == sccm_pkg::ACT_HEARS || act_r == sccm_pkg::ACT_CONNECTED);
  assign walk_last  = (state_r == sccm_pkg::ST_WALK) && wlast;
  assign drain_vld  = (state_r == sccm_pkg::ST_DRAIN) && pipe_vld_r;

`include "shared_channel_carrier_model_assert.svh"

  `SCCM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `SCCM_ASSERT_NXT(a_query_result, eval_query, out_valid, "query gave no result")
  `SCCM_ASSERT_IMP(a_result_idle, out_valid, !busy, "result shown while sequencer busy")
  `SCCM_ASSERT_IMP(a_count_bound, cnt_we, cnt_wdata <= CW'(NODES), "carrier count above limit")
  `SCCM_ASSERT_NXT(a_walk_end, walk_last, drain_vld, "walk did not drain")

endmodule

`default_nettype wire
